// ----- rtl/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types and constants for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NEWTON_STEPS = 3;

  // operation codes on the input port
  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_NORM  = 3'd3;
  localparam logic [2:0] OP_ROT   = 3'd4;

  typedef enum logic [2:0] {
    CLS_MUL,
    CLS_ADD,
    CLS_SCALE,
    CLS_NORM,
    CLS_ROT,
    CLS_NONE
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [3:0][31:0] a;
    logic [3:0][31:0] b;
  } item_t;

  typedef struct packed {
    logic [3:0][31:0] r;
    logic             sat;
    logic             skip;
  } result_t;

endpackage

// ----- rtl/qau_front.sv -----
// ----------------------------------------------------------------------------
// qau_front
// Input side: takes beats, decodes the operation and holds them in a
// two-entry queue for the execution pipeline.
// ----------------------------------------------------------------------------
module qau_front import qau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] a_w,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] b_w,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  output logic        head_valid,
  output item_t       head,
  input  logic        take
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       pop_ok;
  item_t      entry;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = take && head_valid;

  always_comb begin
    entry.a = {a_z, a_y, a_x, a_w};
    entry.b = {b_z, b_y, b_x, b_w};
    unique case (operation)
      OP_MUL:   entry.cls = CLS_MUL;
      OP_ADD:   entry.cls = CLS_ADD;
      OP_SCALE: entry.cls = CLS_SCALE;
      OP_NORM:  entry.cls = CLS_NORM;
      OP_ROT:   entry.cls = CLS_ROT;
      default:  entry.cls = CLS_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

// ----- rtl/qau_back.sv -----
// ----------------------------------------------------------------------------
// qau_back
// Execution pipeline: shared product array, Hamilton/rotation sums, and the
// inverse square root path (leading-one search, table seed, Newton steps).
// The whole pipeline advances together whenever its last stage can drain.
// ----------------------------------------------------------------------------
module qau_back import qau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  item_t   in_item,
  output logic    in_take,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  localparam int CL_LEN = 3 * NEWTON_STEPS + 5;
  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MAG_HALF = 64'd1 << (FRAC_BITS - 3);
  localparam logic [33:0] THREE    = 34'd3 << 30;
  localparam logic [7:0]  SH_BASE  = 8'(46 - FRAC_BITS);

  typedef struct packed {
    logic             valid;
    logic             norm;
    logic [3:0][31:0] a;
    logic [3:0][31:0] r;
    logic             sat;
    logic             skip;
    logic [7:0]       s;
  } carry_t;

  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (64'sd1 <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  // {clipped, value}
  function automatic logic [32:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7fff_ffff};
    else if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    else return {1'b0, v[31:0]};
  endfunction

  function automatic logic [15:0] seed_q16(input logic [2:0] idx);
    case (idx)
      3'd0:    return 16'd58617;
      3'd1:    return 16'd49541;
      3'd2:    return 16'd43691;
      3'd3:    return 16'd39520;
      3'd4:    return 16'd36353;
      default: return 16'd33843;
    endcase
  endfunction

  logic en;
  carry_t cl [CL_LEN];

  assign en      = !cl[CL_LEN-1].valid || res_ready;
  assign in_take = en && in_valid;

  // ---------------- stage 1: product array ----------------
  logic                use_a;
  logic [3:0][31:0]    mop;
  logic                v1;
  cls_t                cls1;
  logic [3:0][31:0]    a1, b1;
  logic signed [63:0]  p1 [4][4];
  logic [3:0][32:0]    s1;

  assign use_a = (in_item.cls == CLS_ROT) || (in_item.cls == CLS_NORM);
  assign mop   = use_a ? in_item.a : in_item.b;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      cls1 <= in_item.cls;
      a1   <= in_item.a;
      b1   <= in_item.b;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1[i][j] <= $signed(in_item.a[i]) * $signed(mop[j]);
        end
        s1[i] <= {in_item.a[i][31], in_item.a[i]} + {in_item.b[i][31], in_item.b[i]};
      end
    end
  end

  // ---------------- stage 2: rounding and sums ----------------
  logic signed [63:0] rp [4][4];
  logic signed [63:0] ham [4];
  logic signed [63:0] cf [9];
  logic [32:0]        ham_c [4], add_c [4], scl_c [4], cf_c [9];
  logic               ham_sat, add_sat, scl_sat, cf_sat;
  logic [63:0]        sq_hi, sq_lo, m_next;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) rp[i][j] = rnd_q(p1[i][j]);
    end
    ham[0] = rp[0][0] - rp[1][1] - rp[2][2] - rp[3][3];
    ham[1] = rp[0][1] + rp[1][0] + rp[2][3] - rp[3][2];
    ham[2] = rp[0][2] - rp[1][3] + rp[2][0] + rp[3][1];
    ham[3] = rp[0][3] + rp[1][2] - rp[2][1] + rp[3][0];
    // rotation matrix, operands are A*A here
    cf[0] = rp[0][0] + rp[1][1] - rp[2][2] - rp[3][3];
    cf[1] = (rp[1][2] <<< 1) - (rp[0][3] <<< 1);
    cf[2] = (rp[1][3] <<< 1) + (rp[0][2] <<< 1);
    cf[3] = (rp[1][2] <<< 1) + (rp[0][3] <<< 1);
    cf[4] = rp[0][0] - rp[1][1] + rp[2][2] - rp[3][3];
    cf[5] = (rp[2][3] <<< 1) - (rp[0][1] <<< 1);
    cf[6] = (rp[1][3] <<< 1) - (rp[0][2] <<< 1);
    cf[7] = (rp[2][3] <<< 1) + (rp[0][1] <<< 1);
    cf[8] = rp[0][0] - rp[1][1] - rp[2][2] + rp[3][3];
    ham_sat = 1'b0;
    add_sat = 1'b0;
    scl_sat = 1'b0;
    cf_sat  = 1'b0;
    sq_hi   = '0;
    sq_lo   = '0;
    for (int i = 0; i < 4; i++) begin
      ham_c[i] = clip32(ham[i]);
      add_c[i] = clip32({{31{s1[i][32]}}, s1[i]});
      scl_c[i] = clip32(rp[i][0]);
      ham_sat  = ham_sat | ham_c[i][32];
      add_sat  = add_sat | add_c[i][32];
      scl_sat  = scl_sat | scl_c[i][32];
      sq_hi    = sq_hi + {2'b00, p1[i][i][63:2]};
      sq_lo    = sq_lo + {62'd0, p1[i][i][1:0]};
    end
    for (int k = 0; k < 9; k++) begin
      cf_c[k] = clip32(cf[k]);
      cf_sat  = cf_sat | cf_c[k][32];
    end
    m_next = sq_hi + {2'b00, sq_lo[63:2]};
  end

  logic             v2;
  cls_t             cls2;
  logic [3:0][31:0] a2, b2, r2;
  logic             sat2;
  logic [31:0]      c2 [9];
  logic [63:0]      m2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      cls2 <= cls1;
      a2   <= a1;
      b2   <= b1;
      m2   <= m_next;
      for (int k = 0; k < 9; k++) c2[k] <= cf_c[k][31:0];
      case (cls1)
        CLS_MUL: begin
          for (int i = 0; i < 4; i++) r2[i] <= ham_c[i][31:0];
          sat2 <= ham_sat;
        end
        CLS_ADD: begin
          for (int i = 0; i < 4; i++) r2[i] <= add_c[i][31:0];
          sat2 <= add_sat;
        end
        CLS_SCALE: begin
          for (int i = 0; i < 4; i++) r2[i] <= scl_c[i][31:0];
          sat2 <= scl_sat;
        end
        CLS_ROT: begin
          r2   <= '0;
          sat2 <= cf_sat;
        end
        default: begin
          r2   <= '0;
          sat2 <= 1'b0;
        end
      endcase
    end
  end

  // ---------------- stage 3: rotate products, magnitude test ----------------
  logic [63:0]      mag2;
  logic             skip_n;
  logic [3:0]       nz_n;
  logic [3:0][3:0]  pos_n;

  always_comb begin
    mag2   = (m2 + MAG_HALF) >> (FRAC_BITS - 2);
    skip_n = (mag2 <= 64'd1) || ((mag2 + 64'd1 >= ONE_Q) && (mag2 <= ONE_Q + 64'd1));
    for (int k = 0; k < 4; k++) begin
      nz_n[k]  = |m2[16*k +: 16];
      pos_n[k] = 4'd0;
      for (int b = 0; b < 16; b++) begin
        if (m2[16*k + b]) pos_n[k] = 4'(b);
      end
    end
  end

  logic               v3;
  cls_t               cls3;
  logic [3:0][31:0]   a3, r3;
  logic               sat3, skip3;
  logic signed [63:0] q3 [3][3];
  logic [63:0]        m3;
  logic [3:0]         nz3;
  logic [3:0][3:0]    pos3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      cls3  <= cls2;
      a3    <= a2;
      r3    <= r2;
      sat3  <= sat2;
      skip3 <= skip_n;
      m3    <= m2;
      nz3   <= nz_n;
      pos3  <= pos_n;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          q3[r][c] <= $signed(c2[r*3 + c]) * $signed(b2[c + 1]);
        end
      end
    end
  end

  // ---------------- stage 4: rotate sums, leading one position ----------------
  logic signed [63:0] acc [3];
  logic [32:0]        rot_c [3];
  logic               rot_sat;
  logic [5:0]         p_n;
  logic [7:0]         s_n;
  carry_t             c4n;
  logic [63:0]        m4;

  always_comb begin
    rot_sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc[r]   = rnd_q(q3[r][0]) + rnd_q(q3[r][1]) + rnd_q(q3[r][2]);
      rot_c[r] = clip32(acc[r]);
      rot_sat  = rot_sat | rot_c[r][32];
    end
    p_n = 6'd0;
    for (int k = 0; k < 4; k++) begin
      if (nz3[k]) p_n = {2'(k), pos3[k]};
    end
    // even shift so the leading one lands on bit 30 or 31
    s_n = {2'b00, p_n} - 8'd30 - {7'd0, p_n[0]};

    c4n.valid = v3;
    c4n.norm  = 1'b0;
    c4n.a     = a3;
    c4n.r     = r3;
    c4n.sat   = sat3;
    c4n.skip  = 1'b0;
    c4n.s     = s_n;
    case (cls3)
      CLS_ROT: begin
        c4n.r[0] = '0;
        c4n.r[1] = rot_c[0][31:0];
        c4n.r[2] = rot_c[1][31:0];
        c4n.r[3] = rot_c[2][31:0];
        c4n.sat  = sat3 | rot_sat;
      end
      CLS_NORM: begin
        if (skip3) begin
          c4n.r    = a3;
          c4n.sat  = 1'b0;
          c4n.skip = 1'b1;
        end else begin
          c4n.norm = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) m4 <= m3;
  end

  // ---------------- stage 5: mantissa and table seed ----------------
  logic [63:0] xs;
  logic [31:0] x_n;
  logic [2:0]  seed_idx;
  logic [31:0] nx [NEWTON_STEPS];
  logic [31:0] ny [NEWTON_STEPS+1];

  always_comb begin
    if (!cl[0].s[7]) xs = m4 >> cl[0].s;
    else xs = m4 << (8'd0 - cl[0].s);
    x_n      = xs[31:0];
    seed_idx = x_n[31:29] - 3'd2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0] <= x_n;
      ny[0] <= {2'b00, seed_q16(seed_idx), 14'd0};
    end
  end

  // ---------------- Newton steps, three stages each ----------------
  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
    logic [63:0] yy, xt, yh;
    logic [31:0] xa, ya, ta, yb, hn;
    logic [33:0] ub;

    assign yy = {32'd0, ny[k]} * {32'd0, ny[k]};
    assign xt = {32'd0, xa} * {32'd0, ta};
    assign hn = (ub >= THREE) ? 32'd0 : 32'(THREE - ub);
    assign yh = {32'd0, yb} * {32'd0, hn};

    always_ff @(posedge clk) begin
      if (en) begin
        xa        <= nx[k];
        ya        <= ny[k];
        ta        <= yy[61:30];
        yb        <= ya;
        ub        <= xt[63:30];
        ny[k + 1] <= yh[62:31];
      end
    end

    // the mantissa only travels on while a later step needs it
    if (k < NEWTON_STEPS - 1) begin : g_fwd
      logic [31:0] xb;

      always_ff @(posedge clk) begin
        if (en) begin
          xb        <= xa;
          nx[k + 1] <= xb;
        end
      end
    end
  end

  // ---------------- final scaling: multiply, round, clip ----------------
  logic [7:0]         sh8;
  logic signed [63:0] fprod [4];
  logic [5:0]         fsh;
  logic signed [63:0] fv [4];
  logic [32:0]        fin_c [4];
  logic               fin_sat;
  carry_t             last_n;

  assign sh8 = SH_BASE + {cl[CL_LEN-4].s[7], cl[CL_LEN-4].s[7:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      fsh <= sh8[5:0];
      for (int i = 0; i < 4; i++) begin
        fprod[i] <= $signed(cl[CL_LEN-4].a[i]) * $signed({1'b0, ny[NEWTON_STEPS]});
        fv[i]    <= (fprod[i] + (64'sd1 <<< (fsh - 6'd1))) >>> fsh;
      end
    end
  end

  always_comb begin
    fin_sat = 1'b0;
    last_n  = cl[CL_LEN-2];
    for (int i = 0; i < 4; i++) begin
      fin_c[i] = clip32(fv[i]);
      fin_sat  = fin_sat | fin_c[i][32];
    end
    if (cl[CL_LEN-2].norm) begin
      for (int i = 0; i < 4; i++) last_n.r[i] = fin_c[i][31:0];
      last_n.sat = fin_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CL_LEN; k++) cl[k].valid <= 1'b0;
    end else if (en) begin
      cl[0] <= c4n;
      for (int k = 1; k < CL_LEN - 1; k++) cl[k] <= cl[k-1];
      cl[CL_LEN-1] <= last_n;
    end
  end

  assign res_valid = cl[CL_LEN-1].valid;
  assign res.r     = cl[CL_LEN-1].r;
  assign res.sat   = cl[CL_LEN-1].sat;
  assign res.skip  = cl[CL_LEN-1].skip;

endmodule

// ----- rtl/qau_out.sv -----
// ----------------------------------------------------------------------------
// qau_out
// Two-entry result queue; lets the pipeline keep moving while a result
// waits to be taken.
// ----------------------------------------------------------------------------
module qau_out import qau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_res,
  output logic    in_ready,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       pop_ok;

  assign empty    = (count == 2'd0);
  assign pop_ok   = pop && !empty;
  assign in_ready = (count != 2'd2) || pop_ok;
  assign push_ok  = in_valid && in_ready;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= in_res;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

// ----- rtl/quaternion_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Q16.16 quaternion multiply, add, scale, normalize and vector rotate.
//
// Input channel: a beat is taken on a clock edge with push high and full low.
// Result channel: the oldest result sits on r_* / saturated / norm_skipped
// while empty is low; it leaves on an edge with pop high.
// Throughput: one beat per cycle, every operation, unless the pipeline holds
// for a full result queue. All items go through the same 17-stage execution
// pipeline; the depth is set by the normalize path (magnitude, leading-one
// search, seed, three 3-stage Newton steps, final scale and round).
// Two-entry queues sit on both sides of the pipeline. When the result queue
// is full and not popped, the pipeline holds, the input queue fills and
// full rises; nothing is dropped.
// Reset (rst, synchronous) empties both queues and the pipeline.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] a_w,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] b_w,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] r_w,
  output logic [31:0] r_x,
  output logic [31:0] r_y,
  output logic [31:0] r_z,
  output logic        saturated,
  output logic        norm_skipped
);

  logic    head_valid;
  item_t   head;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    res_ready;
  result_t out_head;

  qau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .a_w        (a_w),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_w        (b_w),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  qau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (head_valid),
    .in_item   (head),
    .in_take   (take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  qau_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_res   (res),
    .in_ready (res_ready),
    .empty    (empty),
    .pop      (pop),
    .head     (out_head)
  );

  assign r_w          = out_head.r[0];
  assign r_x          = out_head.r[1];
  assign r_y          = out_head.r[2];
  assign r_z          = out_head.r[3];
  assign saturated    = out_head.sat;
  assign norm_skipped = out_head.skip;

endmodule
